/* sv/aoc_pkg.sv */
// ----------------------------------------------------------------------------
// aoc_pkg
// Types, widths and constants shared by the alpha-over composite block.
// ----------------------------------------------------------------------------
package aoc_pkg;

   localparam int ChanW  = 8;
   localparam int DenW   = 16;
   localparam int NumW   = 25;
   localparam int QuoW   = 9;
   localparam int NumChan = 3;

   localparam logic [ChanW-1:0] ChanMax = 8'd255;

   // Reciprocal of 255 for a 16-bit dividend: floor(x*257/65536) with correction.
   localparam logic [8:0] Recip255 = 9'd257;

   typedef struct packed {
      logic [NumW-1:0]  rem;
      logic [DenW-1:0]  den;
      logic [QuoW-1:0]  quo;
      logic [ChanW-1:0] alpha;
      logic             zero;
   } lane_type;

   // Floor division of a 16-bit value by 255, saturated at 255.
   function automatic logic [ChanW-1:0] div255(input logic [DenW-1:0] x);
      logic [24:0]      prod;
      logic [8:0]       q;
      logic [DenW:0]    back;
      prod = 25'(x) * 25'(Recip255);
      q = prod[24:16];
      back = 17'(q) * 17'(ChanMax);
      if (17'(x) < back) begin
         q = q - 9'd1;
      end else if (17'(x) - back >= 17'(ChanMax)) begin
         q = q + 9'd1;
      end
      div255 = (q > 9'(ChanMax)) ? ChanMax : q[ChanW-1:0];
   endfunction

endpackage

/* sv/aoc_cell.sv */
// ----------------------------------------------------------------------------
// aoc_cell
// One restoring-division cell: decides one quotient bit for all three color
// lanes and hands the partial remainders to the next cell.
// ----------------------------------------------------------------------------
module aoc_cell #(
   parameter int Bit = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 valid_in,
   input  aoc_pkg::lane_type    lane_in [aoc_pkg::NumChan],
   output logic                 valid_ff,
   output aoc_pkg::lane_type    lane_ff [aoc_pkg::NumChan]
);

   aoc_pkg::lane_type lane_in_c [aoc_pkg::NumChan];
   logic              valid_in_c;

   always_comb begin
      valid_in_c = valid_in;
      for (int i = 0; i < aoc_pkg::NumChan; i++) begin
         lane_in_c[i] = lane_in[i];
         if ((aoc_pkg::NumW'(lane_in[i].den) << Bit) <= lane_in[i].rem &&
             (lane_in[i].den >> (aoc_pkg::NumW - Bit)) == '0) begin
            lane_in_c[i].rem = lane_in[i].rem - (aoc_pkg::NumW'(lane_in[i].den) << Bit);
            lane_in_c[i].quo[Bit] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in_c;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in_c;
      end
   end

endmodule

/* sv/alpha_over_composite_top.sv */
// ----------------------------------------------------------------------------
// alpha_over_composite_top
// Porter-Duff over composite of two straight-alpha RGBA8888 pixels.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while the result side does not stall. The pipeline
// is the product register, the numerator register, a row of nine division cells,
// one quotient bit each, and an output register. A stall on the result side holds the whole pipeline.
module alpha_over_composite_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_top_red,
   input  logic [7:0] req_top_green,
   input  logic [7:0] req_top_blue,
   input  logic [7:0] req_top_alpha,
   input  logic [7:0] req_bottom_red,
   input  logic [7:0] req_bottom_green,
   input  logic [7:0] req_bottom_blue,
   input  logic [7:0] req_bottom_alpha,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_alpha
);

   localparam int NC = aoc_pkg::NumChan;
   localparam int QW = aoc_pkg::QuoW;

   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // Stage 1: per-pixel products.
   logic        s1_valid_ff;
   logic [7:0]  s1_tc_ff [NC];
   logic [7:0]  s1_bc_ff [NC];
   logic [15:0] s1_tw_ff;
   logic [15:0] s1_bw_ff;
   logic [15:0] s1_den_ff;

   logic [7:0]  inv_a;
   logic [15:0] tw_in, bw_in;
   assign inv_a = aoc_pkg::ChanMax - req_top_alpha;
   assign tw_in = 16'(req_top_alpha) * 16'(aoc_pkg::ChanMax);
   assign bw_in = 16'(req_bottom_alpha) * 16'(inv_a);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tc_ff[0] <= req_top_red;
         s1_tc_ff[1] <= req_top_green;
         s1_tc_ff[2] <= req_top_blue;
         s1_bc_ff[0] <= req_bottom_red;
         s1_bc_ff[1] <= req_bottom_green;
         s1_bc_ff[2] <= req_bottom_blue;
         s1_tw_ff    <= tw_in;
         s1_bw_ff    <= bw_in;
         s1_den_ff   <= tw_in + bw_in;
      end
   end

   // Stage 2: numerators and output alpha.
   logic              s2_valid_ff;
   aoc_pkg::lane_type s2_lane_ff [NC];
   aoc_pkg::lane_type s2_lane_in [NC];

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         s2_lane_in[i].rem   = 25'(24'(s1_tc_ff[i]) * 24'(s1_tw_ff))
                             + 25'(24'(s1_bc_ff[i]) * 24'(s1_bw_ff));
         s2_lane_in[i].den   = s1_den_ff;
         s2_lane_in[i].quo   = '0;
         s2_lane_in[i].alpha = aoc_pkg::div255(s1_den_ff);
         s2_lane_in[i].zero  = (s1_den_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_lane_ff <= s2_lane_in;
      end
   end

   // Division cell chain, most significant quotient bit first.
   logic              cv [QW+1];
   aoc_pkg::lane_type cl [QW+1][NC];

   assign cv[0] = s2_valid_ff;
   assign cl[0] = s2_lane_ff;

   for (genvar g = 0; g < QW; g++) begin : g_cell
      aoc_cell #(.Bit(QW - 1 - g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .valid_in (cv[g]),
         .lane_in  (cl[g]),
         .valid_ff (cv[g+1]),
         .lane_ff  (cl[g+1])
      );
   end

   // Output register.
   logic [7:0] chan_in [NC];
   logic [7:0] chan_ff [NC];
   logic [7:0] alpha_ff;

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         if (cl[QW][i].zero) begin
            chan_in[i] = '0;
         end else if (cl[QW][i].quo > QW'(aoc_pkg::ChanMax)) begin
            chan_in[i] = aoc_pkg::ChanMax;
         end else begin
            chan_in[i] = cl[QW][i].quo[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (adv) begin
         rsp_valid <= cv[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         chan_ff  <= chan_in;
         alpha_ff <= cl[QW][0].alpha;
      end
   end

   assign rsp_out_red   = chan_ff[0];
   assign rsp_out_green = chan_ff[1];
   assign rsp_out_blue  = chan_ff[2];
   assign rsp_out_alpha = alpha_ff;

endmodule

/* sv/aoc_checker.sv */
// ----------------------------------------------------------------------------
// aoc_checker
// Port-level checks for the alpha-over composite block.
// ----------------------------------------------------------------------------
module aoc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_alpha
);

   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("Input stalled without a stalled result.");

   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("Input stalled with an empty output.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_out_red))
      else $error("Stalled result changed.");

   // A combined alpha below one full step only happens when both alphas are zero.
   a_zero_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_alpha == 8'd0) |-> rsp_out_red == 8'd0)
      else $error("Transparent result with a nonzero color.");

endmodule

bind alpha_over_composite_top aoc_checker u_aoc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_alpha (rsp_out_alpha)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Alpha-over composite testbench
// Drives top and bottom pixels into the block with random idle and stall
// bursts, predicts each composite pixel in exact integer arithmetic, and
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   class composite_scoreboard;
      pixel_type pending[$];
      int errors = 0;

      function automatic logic [7:0] blend(int unsigned tc, int unsigned bc,
            int unsigned ta, int unsigned ba, int unsigned den);
         int unsigned num;
         int unsigned q;
         num = tc * ta * 255 + bc * ba * (255 - ta);
         if (den == 0) begin
            return 8'd0;
         end
         q = num / den;
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      function void note_transfer(pixel_type t, pixel_type b);
         pixel_type p;
         int unsigned den;
         int unsigned a;
         den = t.alpha * 255 + b.alpha * (255 - t.alpha);
         a = den / 255;
         p.red = blend(t.red, b.red, t.alpha, b.alpha, den);
         p.green = blend(t.green, b.green, t.alpha, b.alpha, den);
         p.blue = blend(t.blue, b.blue, t.alpha, b.alpha, den);
         p.alpha = (a > 255) ? 8'd255 : a[7:0];
         pending.push_back(p);
      endfunction

      function void check_result(pixel_type got);
         pixel_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.red !== e.red) begin
            $display("%0t: red expected %0d actual %0d", $time, e.red, got.red);
            errors++;
         end
         if (got.green !== e.green) begin
            $display("%0t: green expected %0d actual %0d", $time, e.green, got.green);
            errors++;
         end
         if (got.blue !== e.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, e.blue, got.blue);
            errors++;
         end
         if (got.alpha !== e.alpha) begin
            $display("%0t: alpha expected %0d actual %0d", $time, e.alpha, got.alpha);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0] req_top_red = 0, req_top_green = 0, req_top_blue = 0, req_top_alpha = 0;
   logic [7:0] req_bottom_red = 0, req_bottom_green = 0, req_bottom_blue = 0;
   logic [7:0] req_bottom_alpha = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;

   composite_scoreboard board = new();
   bit calm = 0;
   int unsigned cycle_count = 0;

   alpha_over_composite_top dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      pixel_type t, b, r;
      if (!reset && req_valid && !req_stall) begin
         t = '{req_top_red, req_top_green, req_top_blue, req_top_alpha};
         b = '{req_bottom_red, req_bottom_green, req_bottom_blue, req_bottom_alpha};
         board.note_transfer(t, b);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         r = '{rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha};
         board.check_result(r);
      end
   end

   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 14);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end else begin
            n = $urandom_range(1, 20);
            rsp_stall <= 0;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_pixel(pixel_type t, pixel_type b);
      req_valid <= 1;
      {req_top_red, req_top_green, req_top_blue, req_top_alpha} <=
         {t.red, t.green, t.blue, t.alpha};
      {req_bottom_red, req_bottom_green, req_bottom_blue, req_bottom_alpha} <=
         {b.red, b.green, b.blue, b.alpha};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      logic [7:0] lv[6] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
      pixel_type t, b;
      int wait_count;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 4; j++) begin
            t = '{lv[j], lv[5 - j], lv[i], lv[i]};
            b = '{lv[5 - i], lv[j], lv[i], lv[(i + j) % 6]};
            send_pixel(t, b);
            maybe_idle();
         end
      end
      req_valid <= 0;
      wait_count = 0;
      while (board.pending.size() != 0 && wait_count < 5000) begin
         @(posedge clock);
         wait_count++;
      end
      for (int i = 0; i < 950; i++) begin
         if (i == 800) begin
            calm = 1;
         end
         t = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), pick_alpha()};
         b = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), pick_alpha()};
         send_pixel(t, b);
         maybe_idle();
      end
      req_valid <= 0;
      wait_count = 0;
      while (board.pending.size() != 0 && wait_count < 20000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (30) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
sv/aoc_pkg.sv
sv/aoc_cell.sv
sv/alpha_over_composite_top.sv
sv/aoc_checker.sv
tb/testbench.sv
